@@ design/ohss_pkg.sv @@
// Package with the shared types and constants of the OBU header size scanner.
`timescale 1ns / 1ps
package ohss_pkg;

  localparam int SIZE_BITS    = 32;
  localparam int SHIFT_W      = 7;
  localparam int SHIFT_STEP   = 7;
  localparam int SHIFT_SAT    = 64;
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int REC_W        = 78;
  localparam int OUT_TDATA_W  = ((REC_W + 7) / 8) * 8;
  localparam int IN_TDATA_W   = 8;
  localparam logic [7:0] OBU_LIMIT_RESET = 8'd20;
  localparam logic [6:0] LEB_PAYLOAD_MASK = 7'h7f;

  typedef struct packed {
    logic        size_cut_short;
    logic        size_present;
    logic [31:0] payload_size;
    logic [31:0] header_offset;
    logic [3:0]  hdr_type;
    logic [7:0]  obu_index;
  } ohss_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } ohss_q_stat_t;

endpackage

@@ design/ohss_parser.sv @@
// Front end: walks the byte stream as an OBU chain and forms one record per OBU.
`timescale 1ns / 1ps
module ohss_parser
  import ohss_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [7:0] cfg_wr_data,
  input  logic       byte_fire,
  input  logic [7:0] data_byte,
  input  logic       last_byte,
  output logic       rec_push,
  output ohss_rec_t  rec
);

  typedef enum logic [3:0] {
    PH_HEADER = 4'b0001,
    PH_SIZE   = 4'b0010,
    PH_SKIP   = 4'b0100,
    PH_STOP   = 4'b1000
  } phase_t;

  phase_t                 phase_r, phase_nxt;
  logic [7:0]             obu_limit_r;
  logic [31:0]            byte_pos_r, byte_pos_nxt;
  logic [7:0]             obu_cnt_r, obu_cnt_nxt;
  logic [SIZE_BITS-1:0]   acc_r, acc_nxt;
  logic [SHIFT_W-1:0]     shift_r, shift_nxt;
  logic [31:0]            skip_r, skip_nxt;
  logic [3:0]             type_r, type_nxt;
  logic [31:0]            offset_r, offset_nxt;
  logic [SIZE_BITS+6:0]   chunk;
  logic [SIZE_BITS-1:0]   acc_new;
  logic [SIZE_BITS+31:0]  acc_ext;
  logic [31:0]            size_lo;
  logic [31:0]            skip_dec;
  logic                   more;

  always_comb begin
    more     = data_byte[7];
    chunk    = (SIZE_BITS + 7)'(data_byte[6:0] & LEB_PAYLOAD_MASK) << shift_r;
    acc_new  = acc_r;
    if (shift_r < SHIFT_W'(SIZE_BITS)) begin
      acc_new = acc_r | chunk[SIZE_BITS-1:0];
    end
    acc_ext  = {32'd0, acc_new};
    size_lo  = acc_ext[31:0];
    skip_dec = skip_r - 32'd1;

    phase_nxt    = phase_r;
    byte_pos_nxt = byte_pos_r;
    obu_cnt_nxt  = obu_cnt_r;
    acc_nxt      = acc_r;
    shift_nxt    = shift_r;
    skip_nxt     = skip_r;
    type_nxt     = type_r;
    offset_nxt   = offset_r;
    rec_push     = 1'b0;
    rec          = '0;
    rec.obu_index     = obu_cnt_r;
    rec.hdr_type      = type_r;
    rec.header_offset = offset_r;

    if (byte_fire) begin
      case (phase_r)
        PH_HEADER: begin
          if (!last_byte) begin
            if (obu_cnt_r >= obu_limit_r) begin
              phase_nxt = PH_STOP;
            end else begin
              type_nxt   = data_byte[6:3];
              offset_nxt = byte_pos_r;
              if (!data_byte[1]) begin
                rec_push          = 1'b1;
                rec.hdr_type      = data_byte[6:3];
                rec.header_offset = byte_pos_r;
                obu_cnt_nxt       = obu_cnt_r + 8'd1;
                phase_nxt         = PH_STOP;
              end else begin
                acc_nxt   = '0;
                shift_nxt = '0;
                phase_nxt = PH_SIZE;
              end
            end
          end
        end
        PH_SIZE: begin
          acc_nxt = acc_new;
          if (shift_r < SHIFT_W'(SHIFT_SAT)) begin
            shift_nxt = shift_r + SHIFT_W'(SHIFT_STEP);
          end
          if (!more || last_byte) begin
            rec_push           = 1'b1;
            rec.payload_size   = size_lo;
            rec.size_present   = 1'b1;
            rec.size_cut_short = more;
            obu_cnt_nxt        = obu_cnt_r + 8'd1;
            skip_nxt           = size_lo;
            phase_nxt          = (size_lo == 32'd0) ? PH_HEADER : PH_SKIP;
          end
        end
        PH_SKIP: begin
          skip_nxt = skip_dec;
          if (skip_dec == 32'd0) begin
            phase_nxt = PH_HEADER;
          end
        end
        default: begin
        end
      endcase

      byte_pos_nxt = byte_pos_r + 32'd1;
      if (last_byte) begin
        phase_nxt    = PH_HEADER;
        byte_pos_nxt = '0;
        obu_cnt_nxt  = '0;
        acc_nxt      = '0;
        shift_nxt    = '0;
        skip_nxt     = '0;
        type_nxt     = '0;
        offset_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      obu_limit_r <= OBU_LIMIT_RESET;
      byte_pos_r  <= '0;
      obu_cnt_r   <= '0;
      acc_r       <= '0;
      shift_r     <= '0;
      skip_r      <= '0;
      type_r      <= '0;
      offset_r    <= '0;
    end else begin
      phase_r    <= phase_nxt;
      byte_pos_r <= byte_pos_nxt;
      obu_cnt_r  <= obu_cnt_nxt;
      acc_r      <= acc_nxt;
      shift_r    <= shift_nxt;
      skip_r     <= skip_nxt;
      type_r     <= type_nxt;
      offset_r   <= offset_nxt;
      if (cfg_wr_en) begin
        obu_limit_r <= cfg_wr_data;
      end
    end
  end

endmodule

@@ design/ohss_queue.sv @@
// Short record queue between the parser and the output stage.
`timescale 1ns / 1ps
module ohss_queue
  import ohss_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  ohss_rec_t    push_rec,
  input  logic         pop,
  output ohss_rec_t    head_rec,
  output ohss_q_stat_t stat
);

  ohss_rec_t          mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]  cnt_r;
  logic               do_push, do_pop;

  assign stat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_rec   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      cnt_r <= cnt_r + QCNT_W'(do_push) - QCNT_W'(do_pop);
    end
  end

endmodule

@@ design/ohss_out.sv @@
// Back end: output register that drains the queue onto the result stream.
`timescale 1ns / 1ps
module ohss_out
  import ohss_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  ohss_q_stat_t           q_stat,
  input  ohss_rec_t              head_rec,
  output logic                   pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  logic      valid_r;
  ohss_rec_t rec_r;

  assign pop        = !q_stat.empty && (!valid_r || out_tready);
  assign out_tvalid = valid_r;
  assign out_tdata  = {(OUT_TDATA_W - REC_W)'(0), rec_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!valid_r || out_tready) begin
      valid_r <= !q_stat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      rec_r <= head_rec;
    end
  end

endmodule

@@ design/obu_header_size_scanner_top.sv @@
// Top level of the OBU header size scanner.
`timescale 1ns / 1ps
// The scanner takes one payload byte per cycle and reports one word per OBU
// header it finds; the record formed at the byte that completes the OBU's size
// field (or its header, when there is none) goes through the record queue and
// output register. Input ready stays high unless the four-entry queue in front
// of the output register is full, which only happens while the result stream
// is stalled. The OBU limit may be written only while no payload is in flight.
module obu_header_size_scanner_top
  import ohss_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wr_en,
  input  logic [7:0]             cfg_wr_data,   // obu_limit
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,      // [7:0] data_byte
  input  logic                   in_tlast,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [7:0] obu_index, [11:8] hdr_type, [43:12] header_offset,
  // [75:44] payload_size, [76] size_present, [77] size_cut_short, [79:78] zero
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  ohss_q_stat_t q_stat;
  ohss_rec_t    push_rec, head_rec;
  logic         push, pop, byte_fire;

  assign in_tready = !q_stat.full;
  assign byte_fire = in_tvalid && in_tready;

  ohss_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .byte_fire   (byte_fire),
    .data_byte   (in_tdata[7:0]),
    .last_byte   (in_tlast),
    .rec_push    (push),
    .rec         (push_rec)
  );

  ohss_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .head_rec (head_rec),
    .stat     (q_stat)
  );

  ohss_out u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .head_rec   (head_rec),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

@@ design/ohss_checker.sv @@
// Port-level checker for the OBU header size scanner, bound to the top level.
`timescale 1ns / 1ps
module ohss_checker
  import ohss_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("Result word changed while stalled.");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("Result valid right after reset.");

  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_TDATA_W-1:REC_W] == '0)
    else $error("Padding bits of result word are not zero.");

  a_cut_needs_size: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[77] |-> out_tdata[76])
    else $error("Cut-short flag set without a size field.");

  a_no_size_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tdata[76] |-> out_tdata[75:44] == 32'd0)
    else $error("Nonzero size reported for an OBU without a size field.");

endmodule

bind obu_header_size_scanner_top ohss_checker u_ohss_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

@@ tb/tb.sv @@
// Testbench for the OBU header size scanner: byte stream stimulus, scan prediction, word checks.
`timescale 1ns / 1ps
module tb;
  import ohss_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_STALL  = 300;
  localparam int DRAIN_TAIL  = 8;

  typedef enum logic [1:0] {SCAN_HEADER, SCAN_SIZE, SCAN_SKIP, SCAN_STOP} scan_phase_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } pay_byte_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_wr_en = 1'b0;
  logic [7:0]             cfg_wr_data = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  pay_byte_t   byte_q[$];
  logic [7:0]  frame_q[$];
  ohss_rec_t   obu_q[$];
  int          bytes_queued = 0;
  int          bytes_taken = 0;
  int          err_cnt = 0;
  int          cycle_cnt = 0;
  int          src_idle_pct = 0;
  int          sink_idle_pct = 0;
  logic        stall_kick = 1'b0;
  int          stall_left = 0;
  pay_byte_t   cur_byte;
  ohss_rec_t   got_rec;
  ohss_rec_t   want_rec;

  scan_phase_t          scan_phase = SCAN_HEADER;
  logic [7:0]           scan_limit = OBU_LIMIT_RESET;
  logic [31:0]          byte_pos = '0;
  logic [7:0]           obu_count = '0;
  logic [SIZE_BITS-1:0] size_acc = '0;
  logic [SHIFT_W-1:0]   shift_amt = '0;
  logic [31:0]          skip_left = '0;
  logic [3:0]           cur_type = '0;
  logic [31:0]          cur_offset = '0;

  obu_header_size_scanner_top uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tlast    (in_tlast),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata)
  );

  always #5 clk = ~clk;

  function automatic void push_obu(input logic [31:0] size, input logic present,
                                   input logic cut);
    ohss_rec_t rec;
    rec.obu_index      = obu_count;
    rec.hdr_type       = cur_type;
    rec.header_offset  = cur_offset;
    rec.payload_size   = size;
    rec.size_present   = present;
    rec.size_cut_short = cut;
    obu_q.push_back(rec);
    obu_count = obu_count + 8'd1;
  endfunction

  function automatic void scan_byte(input logic [7:0] b, input logic last);
    logic [SIZE_BITS-1:0] chunk;
    chunk = '0;
    case (scan_phase)
      SCAN_HEADER: begin
        if (!last) begin
          if (obu_count >= scan_limit) begin
            scan_phase = SCAN_STOP;
          end else begin
            cur_type   = b[6:3];
            cur_offset = byte_pos;
            if (!b[1]) begin
              push_obu('0, 1'b0, 1'b0);
              scan_phase = SCAN_STOP;
            end else begin
              size_acc   = '0;
              shift_amt  = '0;
              scan_phase = SCAN_SIZE;
            end
          end
        end
      end
      SCAN_SIZE: begin
        chunk[6:0] = b[6:0];
        if (shift_amt < SIZE_BITS) size_acc = size_acc | (chunk << shift_amt);
        if (shift_amt < SHIFT_SAT) shift_amt = shift_amt + SHIFT_W'(SHIFT_STEP);
        if (!b[7] || last) begin
          push_obu(size_acc[31:0], 1'b1, b[7]);
          skip_left  = size_acc[31:0];
          scan_phase = (size_acc[31:0] == 0) ? SCAN_HEADER : SCAN_SKIP;
        end
      end
      SCAN_SKIP: begin
        skip_left = skip_left - 1;
        if (skip_left == 0) scan_phase = SCAN_HEADER;
      end
      default: begin
      end
    endcase
    byte_pos = byte_pos + 1;
    if (last) begin
      scan_phase = SCAN_HEADER;
      byte_pos   = '0;
      obu_count  = '0;
      size_acc   = '0;
      shift_amt  = '0;
      skip_left  = '0;
      cur_type   = '0;
      cur_offset = '0;
    end
  endfunction

  task automatic log_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    err_cnt++;
  endtask

  task automatic add_header(input logic [3:0] hdr_type, input logic size_flag);
    frame_q.push_back({1'($urandom), hdr_type, 1'($urandom), size_flag, 1'($urandom)});
  endtask

  task automatic add_leb(input int unsigned val, input int pad);
    int unsigned v;
    int i;
    v = val;
    forever begin
      frame_q.push_back({(v > 127) || (pad > 0), v[6:0]});
      v = v >> 7;
      if (v == 0) break;
    end
    for (i = 0; i < pad; i++) frame_q.push_back({i != pad - 1, 7'h00});
  endtask

  task automatic commit_frame();
    int i;
    for (i = 0; i < frame_q.size(); i++) begin
      byte_q.push_back({frame_q[i], i == frame_q.size() - 1});
      bytes_queued++;
    end
    frame_q.delete();
  endtask

  task automatic random_frames(input int target);
    int start;
    int kind;
    int n;
    int i;
    int sz;
    int keep;
    start = bytes_queued;
    while (bytes_queued - start < target) begin
      frame_q.delete();
      kind = $urandom_range(0, 99);
      if (kind < 70) begin
        n = $urandom_range(1, 5);
        for (i = 0; i < n; i++) begin
          sz = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
          add_header(4'($urandom), 1'b1);
          add_leb(sz, ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0);
          repeat (sz) frame_q.push_back(8'($urandom));
        end
        case ($urandom_range(0, 4))
          0: begin
          end
          1: begin
            add_header(4'($urandom), 1'($urandom));
          end
          2: begin
            add_header(4'($urandom), 1'b1);
            frame_q.push_back({1'b1, 7'($urandom)});
          end
          3: begin
            keep = $urandom_range(1, frame_q.size());
            while (frame_q.size() > keep) void'(frame_q.pop_back());
          end
          default: begin
            add_header(4'($urandom), 1'b0);
            repeat ($urandom_range(0, 3)) frame_q.push_back(8'($urandom));
          end
        endcase
      end else if (kind < 85) begin
        add_header(4'($urandom), 1'b1);
        n = $urandom_range(5, 11);
        for (i = 0; i < n; i++) begin
          frame_q.push_back({(i != n - 1) || ($urandom_range(0, 3) == 0), 7'($urandom)});
        end
        repeat ($urandom_range(0, 4)) frame_q.push_back(8'($urandom));
      end else begin
        repeat ($urandom_range(1, 12)) frame_q.push_back(8'($urandom));
      end
      commit_frame();
    end
  endtask

  task automatic wait_idle();
    while (bytes_taken != bytes_queued || obu_q.size() != 0) @(posedge clk);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  task automatic set_limit(input logic [7:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    scan_limit = value;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        scan_byte(in_tdata[7:0], in_tlast);
        bytes_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (byte_q.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
          cur_byte = byte_q.pop_front();
          in_tvalid <= 1'b1;
          in_tdata  <= cur_byte.data;
          in_tlast  <= cur_byte.last;
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        got_rec = ohss_rec_t'(out_tdata[REC_W-1:0]);
        if (obu_q.size() == 0) begin
          log_mismatch($sformatf("unexpected word %h", got_rec));
        end else begin
          want_rec = obu_q.pop_front();
          if (got_rec.obu_index !== want_rec.obu_index)
            log_mismatch($sformatf("obu_index got %0d want %0d",
                                   got_rec.obu_index, want_rec.obu_index));
          if (got_rec.hdr_type !== want_rec.hdr_type)
            log_mismatch($sformatf("hdr_type got %0d want %0d",
                                   got_rec.hdr_type, want_rec.hdr_type));
          if (got_rec.header_offset !== want_rec.header_offset)
            log_mismatch($sformatf("header_offset got %0d want %0d",
                                   got_rec.header_offset, want_rec.header_offset));
          if (got_rec.payload_size !== want_rec.payload_size)
            log_mismatch($sformatf("payload_size got %0d want %0d",
                                   got_rec.payload_size, want_rec.payload_size));
          if (got_rec.size_present !== want_rec.size_present)
            log_mismatch($sformatf("size_present got %b want %b",
                                   got_rec.size_present, want_rec.size_present));
          if (got_rec.size_cut_short !== want_rec.size_cut_short)
            log_mismatch($sformatf("size_cut_short got %b want %b",
                                   got_rec.size_cut_short, want_rec.size_cut_short));
        end
      end
      out_tready <= (stall_left == 0) && ($urandom_range(0, 99) >= sink_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left <= 0;
    end else if (stall_kick) begin
      stall_left <= LONG_STALL;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    int i;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    src_idle_pct  = 17;
    sink_idle_pct = 59;

    // A header on the final byte is ignored.
    frame_q = '{8'h12};
    commit_frame();
    // A header without a size field stops the scan.
    frame_q = '{8'h78, 8'hAA, 8'h55};
    commit_frame();
    // Zero size, then an over-long size whose skip runs past the end.
    frame_q = '{8'h02, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h01};
    commit_frame();
    // The payload ends inside the size field.
    frame_q = '{8'h0A, 8'h80};
    commit_frame();
    frame_q = '{8'h32, 8'h01, 8'hAB, 8'h30, 8'h00};
    commit_frame();
    wait_idle();

    set_limit(8'd1);
    random_frames(120);
    wait_idle();

    set_limit(8'($urandom_range(2, 6)));
    random_frames(120);
    wait_idle();

    src_idle_pct  = 59;
    sink_idle_pct = 17;
    set_limit(8'd255);
    @(posedge clk);
    stall_kick <= 1'b1;
    @(posedge clk);
    stall_kick <= 1'b0;
    // Enough zero-size OBUs in one payload to run into the limit.
    for (i = 0; i < 257; i++) begin
      add_header(4'($urandom), 1'b1);
      frame_q.push_back(8'h00);
    end
    frame_q.push_back(8'($urandom));
    commit_frame();
    random_frames(60);
    wait_idle();

    src_idle_pct  = 0;
    sink_idle_pct = 0;
    set_limit(OBU_LIMIT_RESET);
    random_frames(150);
    wait_idle();

    if (err_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
